>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the echo ranger block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication violated");

// The expression must never be true.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error("assertion failed: forbidden condition seen");

`endif

>>> design/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Types, register codes and the centimeter conversion for the echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

	localparam int TICK_W   = 10;
	localparam int TMO_W    = 16;
	localparam int PER_W    = 16;
	localparam int OBS_W    = 11;
	localparam int CFG_W    = 16;
	localparam int ACC_W    = 17;
	localparam int TIME_W   = 32;
	localparam int DIST_W   = 12;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 24;

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	// Reset values of the configuration registers.
	localparam logic [TICK_W-1:0] TICK_RST = 10'd50;
	localparam logic [TMO_W-1:0]  TMO_RST  = 16'd40000;
	localparam logic [PER_W-1:0]  PER_RST  = 16'd80;
	localparam logic [OBS_W-1:0]  OBS_RST  = 11'd20;

	localparam logic signed [DIST_W-1:0] DIST_NONE = -12'sd1;

	// x / 58 is computed as (x >> 1) / 29, and y / 29 as (y * 72316) >> 21.
	// The reciprocal error (12) stays below 2^(21-16), so the result is exact
	// for every 16-bit y.
	localparam logic [16:0] RECIP29   = 17'd72316;
	localparam int          RECIP_SH  = 21;

	typedef enum logic [1:0] {
		REG_TICK_US     = 2'd0,
		REG_TIMEOUT_US  = 2'd1,
		REG_PERIOD_MS   = 2'd2,
		REG_OBSTACLE_CM = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [TICK_W-1:0] tick_us;
		logic [TMO_W-1:0]  timeout_us;
		logic [PER_W-1:0]  period_ms;
		logic [OBS_W-1:0]  obstacle_cm;
	} cfg_t;

	typedef struct packed {
		logic              kind;
		logic              echo_level;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic                     timed_out;
		logic                     done_res;
		logic                     obstacle;
		logic signed [DIST_W-1:0] distance_cm;
		logic                     busy_res;
		logic                     trigger_pulse;
	} res_t;

	function automatic logic [DIST_W-1:0] div58(input logic [ACC_W-1:0] x);
		logic [15:0] y;
		logic [32:0] prod;
		y    = x[ACC_W-1:1];
		prod = {17'd0, y} * {16'd0, RECIP29};
		return prod[RECIP_SH +: DIST_W];
	endfunction

endpackage

>>> design/uer_cfg.sv
// ----------------------------------------------------------------------------
// uer_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module uer_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output uer_pkg::cfg_t       cfg
);
	import uer_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_us     <= TICK_RST;
			cfg_q.timeout_us  <= TMO_RST;
			cfg_q.period_ms   <= PER_RST;
			cfg_q.obstacle_cm <= OBS_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TICK_US:     cfg_q.tick_us     <= cfg_data[TICK_W-1:0];
				REG_TIMEOUT_US:  cfg_q.timeout_us  <= cfg_data[TMO_W-1:0];
				REG_PERIOD_MS:   cfg_q.period_ms   <= cfg_data[PER_W-1:0];
				REG_OBSTACLE_CM: cfg_q.obstacle_cm <= cfg_data[OBS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/uer_core.sv
// ----------------------------------------------------------------------------
// uer_core
// Measurement state and the single-pass update for one item.
// ----------------------------------------------------------------------------
module uer_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  uer_pkg::item_t item,
	input  uer_pkg::cfg_t  cfg,
	output uer_pkg::res_t  res
);
	import uer_pkg::*;

	logic [ACC_W-1:0]          echo_time_q, echo_time_n;
	logic [ACC_W-1:0]          wait_time_q, wait_time_n;
	logic                      measuring_q, measuring_n;
	logic                      echo_seen_q, echo_seen_n;
	logic signed [DIST_W-1:0]  last_dist_q, last_dist_n;
	logic [TIME_W-1:0]         last_start_q, last_start_n;

	logic [TIME_W-1:0] elapsed;
	logic [ACC_W:0]    wait_sum;
	logic [ACC_W:0]    echo_sum;
	logic              trig, done, tmo;

	assign elapsed  = item.now_ms - last_start_q;
	assign wait_sum = {1'b0, wait_time_q} + {{(ACC_W+1-TICK_W){1'b0}}, cfg.tick_us};
	assign echo_sum = {1'b0, echo_time_q} + {{(ACC_W+1-TICK_W){1'b0}}, cfg.tick_us};

	always_comb begin
		echo_time_n  = echo_time_q;
		wait_time_n  = wait_time_q;
		measuring_n  = measuring_q;
		echo_seen_n  = echo_seen_q;
		last_dist_n  = last_dist_q;
		last_start_n = last_start_q;
		trig = 1'b0;
		done = 1'b0;
		tmo  = 1'b0;
		if (item.kind) begin
			if (elapsed >= {{(TIME_W-PER_W){1'b0}}, cfg.period_ms} && !measuring_q) begin
				last_start_n = item.now_ms;
				echo_time_n  = '0;
				wait_time_n  = '0;
				echo_seen_n  = 1'b0;
				measuring_n  = 1'b1;
				trig         = 1'b1;
			end
		end else if (measuring_q) begin
			wait_time_n = wait_sum[ACC_W] ? ACC_MAX : wait_sum[ACC_W-1:0];
			if (item.echo_level) begin
				echo_seen_n = 1'b1;
				echo_time_n = echo_sum[ACC_W] ? ACC_MAX : echo_sum[ACC_W-1:0];
			end else if (echo_seen_q) begin
				last_dist_n = div58(echo_time_q);
				measuring_n = 1'b0;
				done        = 1'b1;
			end
			// An echo added on this tick still counts toward the timeout.
			if (measuring_n && wait_time_n >= {{(ACC_W-TMO_W){1'b0}}, cfg.timeout_us}) begin
				last_dist_n = DIST_NONE;
				measuring_n = 1'b0;
				tmo         = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_time_q  <= '0;
			wait_time_q  <= '0;
			measuring_q  <= 1'b0;
			echo_seen_q  <= 1'b0;
			last_dist_q  <= DIST_NONE;
			last_start_q <= '0;
		end else if (en) begin
			echo_time_q  <= echo_time_n;
			wait_time_q  <= wait_time_n;
			measuring_q  <= measuring_n;
			echo_seen_q  <= echo_seen_n;
			last_dist_q  <= last_dist_n;
			last_start_q <= last_start_n;
		end
	end

	always_comb begin
		res.trigger_pulse = trig;
		res.busy_res      = measuring_n;
		res.distance_cm   = last_dist_n;
		res.obstacle      = !last_dist_n[DIST_W-1] && (last_dist_n != '0) &&
			(last_dist_n[DIST_W-2:0] < cfg.obstacle_cm);
		res.done_res      = done;
		res.timed_out     = tmo;
	end

endmodule

>>> design/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// Ultrasonic ranging sequencer: scheduler calls start measurements, sample
// ticks accumulate echo and wait time and produce a distance in centimeters.
// ----------------------------------------------------------------------------
// An item is held in the input register and its result in the output register.
// Throughput: one item per cycle while m_tready is high; the input and output
// registers decouple the two sides, so an item is taken while a result waits.
// The state update (add, compare, divide by 58 as a reciprocal multiply) is
// combinational between the input register and the output register.
// Reset (arst_n low, asynchronous): empty pipeline, idle, distance -1,
// configuration at tick 50 us, timeout 40000 us, period 80 ms, obstacle 20 cm.
`include "assert_macros.svh"

module ultrasonic_echo_ranger_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Input item channel.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [0] echo_level, [32:1] now_ms, rest zero
	input  logic        s_tuser,   // [0] kind: 0 sample tick, 1 scheduler call
	// Result item channel.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] trigger_pulse, [1] busy_res,
	                               // [13:2] distance_cm, [14] obstacle,
	                               // [15] done_res, [16] timed_out, rest zero
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import uer_pkg::*;

	// Input register stage. An item waits here until the output register
	// can take its result; the measurement state moves forward at that moment.
	logic  valid_s1;
	item_t item_s1;
	logic  adv;

	// Output register.
	logic  out_valid_q;
	res_t  res_q;

	cfg_t  cfg;
	res_t  res;

	// The held item moves on when the output register is empty or drained
	// in this same cycle.
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind       <= s_tuser;
			item_s1.echo_level <= s_tdata[0];
			item_s1.now_ms     <= s_tdata[32:1];
		end
	end

	uer_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	uer_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, res_q};

	// A measurement that starts on an item is still running after it.
	`ASSERT_IMPLY(a_trig_busy, clk, arst_n, m_tvalid && res_q.trigger_pulse, res_q.busy_res)
	// An abandoned measurement always reports no distance.
	`ASSERT_IMPLY(a_tmo_dist, clk, arst_n, m_tvalid && res_q.timed_out,
		res_q.distance_cm == DIST_NONE && !res_q.busy_res)
	// A measurement ends in at most one way, and never on the item that starts it.
	`ASSERT_NEVER(a_end_once, clk, arst_n,
		m_tvalid && ((res_q.done_res && res_q.timed_out) ||
		(res_q.trigger_pulse && (res_q.done_res || res_q.timed_out))))
	// The state only moves when a held item has somewhere to go.
	`ASSERT_IMPLY(a_adv_room, clk, arst_n, adv, valid_s1 && (!out_valid_q || m_tready))

endmodule
